FILE: rtl/yrgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yrgb_pkg - shared types and constants for the YCbCr pair converter
// Fixed-point reciprocals of the four chroma coefficients and the term types.
// ----------------------------------------------------------------------------
package yrgb_pkg;

  // Fraction bits of the reciprocal constants. With a chroma magnitude of at
  // most 128 the rounding error stays below 1/50000, the finest step of any
  // exact quotient, so floor(mag * R >> FRAC) equals the exact quotient.
  localparam int unsigned FRAC = 24;
  localparam int unsigned RECIP_W = 26;
  localparam int unsigned PROD_W = RECIP_W + 8;
  localparam int unsigned TERM_W = 9;
  localparam int unsigned SUM_W = 11;

  // ceil(K * 2^FRAC / D) on the reduced ratios.
  localparam logic [63:0] RECIP_UB_W = ((64'd443 << FRAC) + 64'd249) / 64'd250;
  localparam logic [63:0] RECIP_UG_W = ((64'd17207 << FRAC) + 64'd49999) / 64'd50000;
  localparam logic [63:0] RECIP_VG_W = ((64'd35707 << FRAC) + 64'd49999) / 64'd50000;
  localparam logic [63:0] RECIP_VR_W = ((64'd701 << FRAC) + 64'd499) / 64'd500;

  localparam logic [RECIP_W-1:0] RECIP_UB = RECIP_UB_W[RECIP_W-1:0];
  localparam logic [RECIP_W-1:0] RECIP_UG = RECIP_UG_W[RECIP_W-1:0];
  localparam logic [RECIP_W-1:0] RECIP_VG = RECIP_VG_W[RECIP_W-1:0];
  localparam logic [RECIP_W-1:0] RECIP_VR = RECIP_VR_W[RECIP_W-1:0];

  localparam logic [7:0] CHROMA_ZERO = 8'd128;

  // Signed chroma terms shared by both pixel lanes.
  typedef struct packed {
    logic signed [TERM_W-1:0] ub;
    logic signed [TERM_W-1:0] ug;
    logic signed [TERM_W-1:0] vg;
    logic signed [TERM_W-1:0] vr;
  } yrgb_terms_t;

  // Pipeline enables from the top level to the chroma unit.
  typedef struct packed {
    logic load_mul;
  } yrgb_ctl_t;

endpackage : yrgb_pkg
`default_nettype wire

FILE: rtl/yrgb_chroma.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yrgb_chroma - chroma term unit
// Multiplies the chroma magnitudes by the coefficient reciprocals, registers
// the truncated quotients and restores their signs.
// ----------------------------------------------------------------------------
module yrgb_chroma (
  input  wire logic                 clk,
  input  wire yrgb_pkg::yrgb_ctl_t  ctl,
  input  wire logic [7:0]           chroma_blue,
  input  wire logic [7:0]           chroma_red,
  output yrgb_pkg::yrgb_terms_t     terms
);
  import yrgb_pkg::*;

  logic [7:0]        mag_c;
  logic [7:0]        mag_d;
  logic              neg_c_in;
  logic              neg_d_in;
  logic [PROD_W-1:0] prod_ub;
  logic [PROD_W-1:0] prod_ug;
  logic [PROD_W-1:0] prod_vg;
  logic [PROD_W-1:0] prod_vr;

  logic [TERM_W-1:0] q_ub;
  logic [TERM_W-1:0] q_ug;
  logic [TERM_W-1:0] q_vg;
  logic [TERM_W-1:0] q_vr;
  logic              neg_c;
  logic              neg_d;

  // Sign and magnitude of the offset chroma; 128 - x never exceeds 128.
  assign neg_c_in = (chroma_blue < CHROMA_ZERO);
  assign neg_d_in = (chroma_red < CHROMA_ZERO);
  assign mag_c = neg_c_in ? (CHROMA_ZERO - chroma_blue) : (chroma_blue - CHROMA_ZERO);
  assign mag_d = neg_d_in ? (CHROMA_ZERO - chroma_red) : (chroma_red - CHROMA_ZERO);

  assign prod_ub = PROD_W'(mag_c) * PROD_W'(RECIP_UB);
  assign prod_ug = PROD_W'(mag_c) * PROD_W'(RECIP_UG);
  assign prod_vg = PROD_W'(mag_d) * PROD_W'(RECIP_VG);
  assign prod_vr = PROD_W'(mag_d) * PROD_W'(RECIP_VR);

  always_ff @(posedge clk) begin
    if (ctl.load_mul) begin
      q_ub  <= prod_ub[FRAC+TERM_W-1:FRAC];
      q_ug  <= prod_ug[FRAC+TERM_W-1:FRAC];
      q_vg  <= prod_vg[FRAC+TERM_W-1:FRAC];
      q_vr  <= prod_vr[FRAC+TERM_W-1:FRAC];
      neg_c <= neg_c_in;
      neg_d <= neg_d_in;
    end
  end

  // Truncation toward zero: negate the floored magnitude.
  assign terms.ub = neg_c ? -$signed(q_ub) : $signed(q_ub);
  assign terms.ug = neg_c ? -$signed(q_ug) : $signed(q_ug);
  assign terms.vg = neg_d ? -$signed(q_vg) : $signed(q_vg);
  assign terms.vr = neg_d ? -$signed(q_vr) : $signed(q_vr);

endmodule : yrgb_chroma
`default_nettype wire

FILE: rtl/yrgb_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yrgb_lane - one pixel lane
// Combines the shared chroma terms with one luma sample, saturates and packs 5-6-5.
// ----------------------------------------------------------------------------
module yrgb_lane (
  input  wire logic [7:0]             luma,
  input  wire yrgb_pkg::yrgb_terms_t  terms,
  output logic [15:0]                 rgb
);
  import yrgb_pkg::*;

  logic signed [SUM_W-1:0] y_s;
  logic signed [SUM_W-1:0] sum_b;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_r;
  logic [7:0]              b;
  logic [7:0]              g;
  logic [7:0]              r;

  function automatic logic [7:0] sat_byte(input logic signed [SUM_W-1:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 255) begin
      res = 8'hFF;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  assign y_s   = $signed({3'b000, luma});
  assign sum_b = y_s + SUM_W'(terms.ub);
  assign sum_g = y_s - SUM_W'(terms.ug) - SUM_W'(terms.vg);
  assign sum_r = y_s + SUM_W'(terms.vr);

  assign b = sat_byte(sum_b);
  assign g = sat_byte(sum_g);
  assign r = sat_byte(sum_r);

  assign rgb = {r[7:3], g[7:2], b[7:3]};

endmodule : yrgb_lane
`default_nettype wire

FILE: rtl/yuv420_to_rgb565_pair.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yuv420_to_rgb565_pair - YCbCr to RGB565 converter, one pixel pair per word
// Two-stage pipeline: chroma terms, then two pixel lanes and a packing stage.
// ----------------------------------------------------------------------------
// Each input word carries two adjacent luma samples and the Cb/Cr pair they
// share; each output word holds two RGB565 pixels, left pixel in bits 15:0.
// The block takes one word per clock and keeps that rate as long as the sink
// takes one word per clock. From input acceptance to output valid, the first
// stage registers the four chroma quotients (one 8 x 26 bit constant
// multiply each, truncated toward zero), the second stage runs both pixel
// lanes (add, saturate to 0..255, 5-6-5 pack) into the output register.
// Ready to the source is combinational from the sink's ready through the
// two stages, so stalls propagate in the same cycle and no word is dropped.
// There are no configuration registers; reset clears only the valid flags.
// ----------------------------------------------------------------------------
module yuv420_to_rgb565_pair (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [7:0]  luma_left,
  input  wire logic [7:0]  luma_right,
  input  wire logic [7:0]  chroma_blue,
  input  wire logic [7:0]  chroma_red,
  output logic             pixel_valid,
  input  wire logic        pixel_ready,
  output logic [31:0]      pixel_pair
);
  import yrgb_pkg::*;

  logic        s1_valid;
  logic        s1_valid_next;
  logic        pixel_valid_next;
  logic        out_free;
  logic        out_load;
  logic        s1_load;
  logic [7:0]  s1_luma_left;
  logic [7:0]  s1_luma_right;
  logic [15:0] rgb_left;
  logic [15:0] rgb_right;
  yrgb_ctl_t   ctl;
  yrgb_terms_t terms;

  // Advance each stage when the one after it can take its word.
  assign out_free   = !pixel_valid || pixel_ready;
  assign out_load   = s1_valid && out_free;
  assign item_ready = !s1_valid || out_free;
  assign s1_load    = item_valid && item_ready;

  assign ctl.load_mul = s1_load;

  always_comb begin
    s1_valid_next = s1_valid;
    if (s1_load) begin
      s1_valid_next = 1'b1;
    end else if (out_load) begin
      s1_valid_next = 1'b0;
    end
  end

  always_comb begin
    pixel_valid_next = pixel_valid;
    if (out_load) begin
      pixel_valid_next = 1'b1;
    end else if (pixel_ready) begin
      pixel_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      s1_valid    <= s1_valid_next;
      pixel_valid <= pixel_valid_next;
    end
  end

  // Hold the luma samples alongside the chroma quotients.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_luma_left  <= luma_left;
      s1_luma_right <= luma_right;
    end
  end

  yrgb_chroma u_chroma (
    .clk         (clk),
    .ctl         (ctl),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red),
    .terms       (terms)
  );

  // Both lanes share the same chroma terms.
  yrgb_lane u_lane_left (
    .luma  (s1_luma_left),
    .terms (terms),
    .rgb   (rgb_left)
  );

  yrgb_lane u_lane_right (
    .luma  (s1_luma_right),
    .terms (terms),
    .rgb   (rgb_right)
  );

  // Merge the lanes into the output word; left pixel in the low half.
  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_pair <= {rgb_right, rgb_left};
    end
  end

endmodule : yuv420_to_rgb565_pair
`default_nettype wire

FILE: rtl/yrgb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yrgb_checker - port-level checks for the pixel pair converter
// Watches the top-level handshakes for latency, stall and reset behavior.
// ----------------------------------------------------------------------------
module yrgb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic [7:0]  luma_left,
  input wire logic [7:0]  luma_right,
  input wire logic [7:0]  chroma_blue,
  input wire logic [7:0]  chroma_red,
  input wire logic        pixel_valid,
  input wire logic        pixel_ready,
  input wire logic [31:0] pixel_pair
);

  // An accepted word leads to a valid output word, which under a stall may still be an older one.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |-> ##2 pixel_valid)
    else $error("accepted word did not reach the output in two cycles");

  // Black in gives black out: Y = 0 with neutral chroma packs to zero. An older
  // word may still sit in the output register, so wait for the sink to take it.
  a_black: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && !pixel_valid && luma_left == 8'd0 &&
     luma_right == 8'd0 && chroma_blue == 8'd128 && chroma_red == 8'd128)
    ##1 pixel_ready |=> pixel_valid && pixel_pair == 32'd0)
    else $error("neutral black word converted to nonzero pixels");

  // An empty output register never back-pressures the source.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !pixel_valid |-> item_ready)
    else $error("input stalled while output register empty");

  // A stalled output word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_pair))
    else $error("stalled output word changed");

  // Reset drops any word in flight.
  a_reset: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("output valid after reset");

endmodule : yrgb_checker

bind yuv420_to_rgb565_pair yrgb_checker u_yrgb_checker (.*);
`default_nettype wire

FILE: verif/tb_yuv420_to_rgb565_pair.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_yuv420_to_rgb565_pair - self-checking bench for the YCbCr pair converter
// Drives luma/chroma words through the valid/ready input, predicts each
// RGB565 pixel pair in integer math and checks every output word in order.
// ----------------------------------------------------------------------------
module tb_yuv420_to_rgb565_pair;
  import yrgb_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [7:0]  luma_left = 8'd0;
  logic [7:0]  luma_right = 8'd0;
  logic [7:0]  chroma_blue = 8'd0;
  logic [7:0]  chroma_red = 8'd0;
  logic        pixel_valid;
  logic        pixel_ready = 1'b0;
  logic [31:0] pixel_pair;

  // Output words still owed by the block, oldest first.
  logic [31:0] expected_pairs[$];
  logic [31:0] head_pair;
  int unsigned mismatch_count = 0;

  // Sink behavior: steady means always ready.
  logic        sink_steady = 1'b0;
  int unsigned sink_hold = 0;

  yuv420_to_rgb565_pair dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .luma_left   (luma_left),
    .luma_right  (luma_right),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_pair  (pixel_pair)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic yrgb_terms_t chroma_terms(input logic [7:0] cb, input logic [7:0] cr);
    yrgb_terms_t t;
    int c;
    int d;
    c = int'(cb) - int'(CHROMA_ZERO);
    d = int'(cr) - int'(CHROMA_ZERO);
    // Integer division truncates toward zero, matching the exact quotients.
    t.ub = TERM_W'((1772 * c) / 1000);
    t.ug = TERM_W'((34414 * c) / 100000);
    t.vg = TERM_W'((35707 * d) / 50000);
    t.vr = TERM_W'((701 * d) / 500);
    return t;
  endfunction

  function automatic logic [7:0] sat_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic logic [15:0] rgb565(input logic [7:0] y, input yrgb_terms_t t);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    b = sat_byte(int'(y) + int'(t.ub));
    g = sat_byte(int'(y) - int'(t.ug) - int'(t.vg));
    r = sat_byte(int'(y) + int'(t.vr));
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [31:0] rgb565_pair(input logic [7:0] yl, input logic [7:0] yr,
                                               input logic [7:0] cb, input logic [7:0] cr);
    yrgb_terms_t t;
    t = chroma_terms(cb, cr);
    return {rgb565(yr, t), rgb565(yl, t)};
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Bias toward the rails so saturation shows up often.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r == 2) return 8'($urandom_range(120, 136));
    return 8'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Sink: random ready with bursts of stalls; steady mode holds ready high.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (sink_steady) begin
      pixel_ready <= 1'b1;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (!pixel_ready) begin
      pixel_ready <= 1'b1;
      sink_hold <= $urandom_range(0, 12);
    end else begin
      pixel_ready <= 1'b0;
      sink_hold <= idle_len();
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every accepted output word against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && pixel_valid && pixel_ready) begin
      if (expected_pairs.size() == 0) begin
        $error("pixel_pair: no word expected, got %h", pixel_pair);
        mismatch_count++;
      end else begin
        head_pair = expected_pairs.pop_front();
        if (pixel_pair !== head_pair) begin
          $error("pixel_pair: expected %h, got %h", head_pair, pixel_pair);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------
  // Idle for the requested gap, present one word and hold it until accepted.
  task automatic send_word(input logic [7:0] yl, input logic [7:0] yr,
                           input logic [7:0] cb, input logic [7:0] cr,
                           input int unsigned gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    luma_left   <= yl;
    luma_right  <= yr;
    chroma_blue <= cb;
    chroma_red  <= cr;
    do @(posedge clk); while (!item_ready);
    expected_pairs.push_back(rgb565_pair(yl, yr, cb, cr));
  endtask

  // Drop valid and hold off until every owed word has come out.
  task automatic wait_drain();
    item_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
  endtask

  // Rails of each field, neutral chroma, saturation both ways, and the
  // smallest nonzero chroma offsets where truncation of negatives matters.
  task automatic test_corners();
    send_word(8'd0,   8'd0,   8'd0,   8'd0,   0);
    send_word(8'd255, 8'd255, 8'd255, 8'd255, 0);
    send_word(8'd0,   8'd255, 8'd128, 8'd128, 0);
    send_word(8'd255, 8'd0,   8'd128, 8'd128, 1);
    send_word(8'd128, 8'd128, 8'd0,   8'd128, 0);
    send_word(8'd128, 8'd128, 8'd255, 8'd128, 0);
    send_word(8'd128, 8'd128, 8'd128, 8'd0,   2);
    send_word(8'd128, 8'd128, 8'd128, 8'd255, 0);
    send_word(8'd10,  8'd245, 8'd0,   8'd0,   0);
    send_word(8'd10,  8'd245, 8'd255, 8'd255, 0);
    send_word(8'd240, 8'd20,  8'd0,   8'd255, 3);
    send_word(8'd240, 8'd20,  8'd255, 8'd0,   0);
    send_word(8'h55,  8'hAA,  8'd127, 8'd129, 0);
    send_word(8'hAA,  8'h55,  8'd129, 8'd127, 0);
    send_word(8'h01,  8'h80,  8'h7F,  8'hFE,  0);
    send_word(8'hFE,  8'h7F,  8'h80,  8'h01,  0);
  endtask

  // Bulk random words with random gaps against a stalling sink.
  task automatic test_random(input int unsigned count);
    repeat (count) begin
      send_word(pick_byte(), pick_byte(), pick_byte(), pick_byte(), idle_len());
    end
  endtask

  // Short bursts, each followed by a full drain before the next.
  task automatic test_drain_bursts();
    repeat (3) begin
      repeat (30) send_word(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 0);
      wait_drain();
    end
  endtask

  // Full rate: no source gaps, sink always ready.
  task automatic test_full_rate();
    sink_steady <= 1'b1;
    repeat (150) send_word(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 0);
    wait_drain();
    sink_steady <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_random(650);
    test_drain_bursts();
    test_full_rate();
    test_random(650);
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_yuv420_to_rgb565_pair: done, clean");
    end else begin
      $display("tb_yuv420_to_rgb565_pair: done, errors");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("tb_yuv420_to_rgb565_pair: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
